FILE: rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// shared types and constants of the seek/arrive steering pipeline
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int FX_W        = 32;   // signed fixed-point vector component
    localparam int CFG_W       = 31;   // unsigned configuration register
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_BITS   = 16;
    localparam int IN_TDATA_W  = 9 * FX_W;
    localparam int OUT_TDATA_W = 128;

    // squared length below this means a length under 1e-4
    localparam logic [63:0] NEAR_THR = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

    localparam int SQRT_STEPS = 32;
    localparam int RAMP_Q_W   = 31;
    localparam int DES_Q_W    = 31;
    localparam int FRC_Q_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SPEED      = 2'd0,
        REG_MAX_FORCE      = 2'd1,
        REG_ARRIVAL_RADIUS = 2'd2
    } cfg_reg_t;

    typedef logic [2:0][FX_W-1:0] vec_t;
    typedef logic [2:0][FX_W:0]   vec33_t;

    typedef struct packed {
        logic vld;
        vec_t d;
        vec_t vel;
        logic tiny;
    } side_sq_t;

    typedef struct packed {
        logic            vld;
        vec_t            d;
        vec_t            vel;
        logic [FX_W-1:0] len;
        logic            near;
        logic            far;
        logic            le;
        logic            zlen;
    } side_rd_t;

    typedef struct packed {
        logic             vld;
        vec_t             vel;
        logic [2:0]       sgn;
        logic             near;
        logic             far;
        logic [CFG_W-1:0] reported;
    } side_dd_t;

    typedef struct packed {
        logic             vld;
        logic             far;
        vec33_t           diff;
        logic [2:0]       dsgn;
        logic [2:0]       ovf;
        logic [CFG_W-1:0] reported;
    } side_fd_t;

endpackage

FILE: rtl/sas_div_pipe.sv
// ----------------------------------------------------------------------------
// sas_div_pipe
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module sas_div_pipe #(
    parameter int DEN_W = 31,
    parameter int Q_W   = 31
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [DEN_W+Q_W-1:0]   num,   // num >> Q_W must be below den
    input  logic [DEN_W-1:0]       den,
    output logic [Q_W-1:0]         quot
);
    localparam int W = DEN_W + Q_W;

    // work word: partial remainder on top, dividend bits / quotient bits below
    logic [W-1:0]     work_reg [Q_W+1];
    logic [DEN_W-1:0] den_reg  [Q_W+1];
    logic [W-1:0]     work_next[Q_W+1];

    assign work_next[0] = num;

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [W:0]     sh;
        logic [DEN_W:0] hi;
        logic [DEN_W:0] dif;
        assign sh  = {work_reg[k-1], 1'b0};
        assign hi  = sh[W:Q_W];
        assign dif = hi - {1'b0, den_reg[k-1]};
        assign work_next[k] = (hi >= {1'b0, den_reg[k-1]})
                            ? {dif[DEN_W-1:0], sh[Q_W-1:1], 1'b1}
                            : {hi[DEN_W-1:0],  sh[Q_W-1:1], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= Q_W; k++)
            begin
                work_reg[k] <= work_next[k];
                den_reg[k]  <= (k == 0) ? den : den_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign quot = work_reg[Q_W][Q_W-1:0];

endmodule

FILE: rtl/seek_arrive_steering.sv
// ----------------------------------------------------------------------------
// seek_arrive_steering
// seek-with-arrival steering force, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   s_t* carries one entity per word: target, position and velocity as
//   signed fixed-point 3d vectors. m_t* returns the steering force and the
//   desired speed. cfg_wr_en/cfg_index/cfg_data write max speed, max force
//   and arrival radius; write them only while no word is in flight.
// throughput: one word per cycle unless the skid holds a result. the work
//   is cut into 138 register stages (square and sum, a 32-step square root,
//   the ramp divider, three desired velocity dividers, three force
//   dividers), most of them doing one bit of a root or a quotient, plus an
//   output register.
// reset: all valid bits clear at once, registers return to 600.0, 100.0
//   and 200.0; s_tready is already high when reset ends.
// stall: a skid register sits behind the output register. while the
//   receiver holds m_tready low the pipeline keeps moving until one result
//   waits in the skid; only then does s_tready drop and every stage hold.
// ----------------------------------------------------------------------------
module seek_arrive_steering (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // target_x, target_y, target_z, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic [sas_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // force_x, force_y, force_z, desired_speed, one zero pad bit
    output logic [sas_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [sas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sas_pkg::CFG_W-1:0]         cfg_data
);
    import sas_pkg::*;

    // saturate a 33-bit signed value to 32 bits
    function automatic logic [FX_W-1:0] sat33(input logic [FX_W:0] v);
        logic [FX_W-1:0] r;
        if (!v[FX_W] && v[FX_W-1])
            r = {1'b0, {(FX_W-1){1'b1}}};
        else if (v[FX_W] && !v[FX_W-1])
            r = {1'b1, {(FX_W-1){1'b0}}};
        else
            r = v[FX_W-1:0];
        return r;
    endfunction

    function automatic logic [FX_W-1:0] abs32(input logic [FX_W-1:0] v);
        return v[FX_W-1] ? (~v + 1'b1) : v;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] max_speed_reg;
    logic [CFG_W-1:0] max_force_reg;
    logic [CFG_W-1:0] arrival_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg      <= 31'd39321600;
            max_force_reg      <= 31'd6553600;
            arrival_radius_reg <= 31'd13107200;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_SPEED:      max_speed_reg      <= cfg_data;
                REG_MAX_FORCE:      max_force_reg      <= cfg_data;
                REG_ARRIVAL_RADIUS: arrival_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: every stage moves unless a result waits in the skid
    logic en;
    logic sk_vld_reg;
    assign en       = !sk_vld_reg;
    assign s_tready = en;

    // ---- stage 1: distance vector, clamped to 32 bits
    side_sq_t s1_reg, s1_next;
    always_comb
    begin
        s1_next       = '0;
        s1_next.vld   = s_tvalid;
        for (int i = 0; i < 3; i++)
        begin
            s1_next.d[i]   = sat33({s_tdata[i*FX_W+FX_W-1], s_tdata[i*FX_W +: FX_W]}
                                 - {s_tdata[(3+i)*FX_W+FX_W-1], s_tdata[(3+i)*FX_W +: FX_W]});
            s1_next.vel[i] = s_tdata[(6+i)*FX_W +: FX_W];
        end
    end

    // ---- stage 2: squares of the components
    side_sq_t         s2_reg;
    logic [2:0][63:0] s2_sq_reg;
    logic [2:0][63:0] s2_sq_next;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s2_sq_next[i] = 64'(abs32(s1_reg.d[i])) * 64'(abs32(s1_reg.d[i]));
    end

    // ---- stage 3 and square root: index 0 holds the sum of squares
    side_sq_t          sq_sb_reg [SQRT_STEPS+1];
    logic [63:0]       rad_reg   [SQRT_STEPS+1];
    logic [33:0]       rem_reg   [SQRT_STEPS+1];
    logic [FX_W-1:0]   root_reg  [SQRT_STEPS+1];
    logic [63:0]       rad_next  [SQRT_STEPS+1];
    logic [33:0]       rem_next  [SQRT_STEPS+1];
    logic [FX_W-1:0]   root_next [SQRT_STEPS+1];
    logic [63:0]       sum_next;
    side_sq_t          s3_next;

    always_comb
    begin
        sum_next      = s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
        s3_next       = s2_reg;
        s3_next.tiny  = sum_next < NEAR_THR;
        rad_next[0]   = sum_next;
        rem_next[0]   = '0;
        root_next[0]  = '0;
    end

    // one result bit per stage, two radicand bits shifted in
    for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
        logic [33:0] r2;
        logic [33:0] trial;
        assign r2    = {rem_reg[j-1][31:0], rad_reg[j-1][63:62]};
        assign trial = {root_reg[j-1], 2'b01};
        assign rad_next[j]  = {rad_reg[j-1][61:0], 2'b00};
        assign rem_next[j]  = (r2 >= trial) ? (r2 - trial) : r2;
        assign root_next[j] = {root_reg[j-1][FX_W-2:0], (r2 >= trial)};
    end

    // ---- stage M: compare against radius, ramp product
    side_rd_t    m_reg, m_next;
    logic [62:0] m_prod_reg, m_prod_next;
    logic [FX_W-1:0] len_w;
    assign len_w = root_reg[SQRT_STEPS];

    always_comb
    begin
        m_next      = '0;
        m_next.vld  = sq_sb_reg[SQRT_STEPS].vld;
        m_next.d    = sq_sb_reg[SQRT_STEPS].d;
        m_next.vel  = sq_sb_reg[SQRT_STEPS].vel;
        m_next.len  = len_w;
        m_next.zlen = len_w == '0;
        m_next.near = sq_sb_reg[SQRT_STEPS].tiny || (len_w == '0);
        m_next.far  = len_w >= {1'b0, arrival_radius_reg};
        m_next.le   = len_w <= {1'b0, arrival_radius_reg};
        m_prod_next = 63'(max_speed_reg) * 63'(len_w);
    end

    // ramp divider: max_speed * len / radius, exact whenever len <= radius
    logic [RAMP_Q_W-1:0] ramp_q;
    side_rd_t            rd_sb_reg [RAMP_Q_W+1];

    sas_div_pipe #(
        .DEN_W (CFG_W),
        .Q_W   (RAMP_Q_W)
    ) u_ramp_div (
        .clk  (clk),
        .en   (en),
        .num  (m_prod_reg[CFG_W+RAMP_Q_W-1:0]),
        .den  (arrival_radius_reg),
        .quot (ramp_q)
    );

    // ---- stage SP: pick the speed used and the speed reported
    side_rd_t         sp_reg;
    logic [CFG_W-1:0] sp_speed_reg, sp_speed_next;
    logic [CFG_W-1:0] sp_rep_reg, sp_rep_next;
    logic [CFG_W-1:0] ramp_w;
    side_rd_t         rd_out;
    assign rd_out = rd_sb_reg[RAMP_Q_W];

    always_comb
    begin
        ramp_w        = (rd_out.zlen || arrival_radius_reg == '0) ? '0 : ramp_q;
        sp_speed_next = rd_out.far ? max_speed_reg : ramp_w;
        sp_rep_next   = rd_out.le  ? ramp_w : max_speed_reg;
    end

    // ---- stage P: |d| * speed for the desired velocity
    side_dd_t         p_reg, p_next;
    logic [FX_W-1:0]  p_len_reg;
    logic [2:0][62:0] p_prod_reg, p_prod_next;

    always_comb
    begin
        p_next          = '0;
        p_next.vld      = sp_reg.vld;
        p_next.vel      = sp_reg.vel;
        p_next.near     = sp_reg.near;
        p_next.far      = sp_reg.far;
        p_next.reported = sp_rep_reg;
        for (int i = 0; i < 3; i++)
        begin
            p_next.sgn[i]  = sp_reg.d[i][FX_W-1];
            p_prod_next[i] = 63'(abs32(sp_reg.d[i])) * 63'(sp_speed_reg);
        end
    end

    // desired velocity dividers, |d| <= len keeps the quotient in 31 bits
    logic [2:0][DES_Q_W-1:0] des_q;
    side_dd_t                dd_sb_reg [DES_Q_W+1];

    for (genvar i = 0; i < 3; i++) begin : g_des
        sas_div_pipe #(
            .DEN_W (FX_W),
            .Q_W   (DES_Q_W)
        ) u_des_div (
            .clk  (clk),
            .en   (en),
            .num  (p_prod_reg[i]),
            .den  (p_len_reg),
            .quot (des_q[i])
        );
    end

    // ---- stage D: desired minus velocity
    side_fd_t d_reg, d_next;
    side_dd_t dd_out;
    assign dd_out = dd_sb_reg[DES_Q_W];

    always_comb
    begin
        logic [FX_W:0] des;
        d_next          = '0;
        d_next.vld      = dd_out.vld;
        d_next.far      = dd_out.far;
        d_next.reported = dd_out.reported;
        for (int i = 0; i < 3; i++)
        begin
            des = dd_out.near ? '0
                : (dd_out.sgn[i] ? -{2'b00, des_q[i]} : {2'b00, des_q[i]});
            d_next.diff[i] = des - {dd_out.vel[i][FX_W-1], dd_out.vel[i]};
        end
    end

    // ---- stage F: |diff| * max_force
    side_fd_t         f_reg, f_next;
    logic [2:0][63:0] f_fm_reg, f_fm_next;
    logic [CFG_W-1:0] frc_den;
    assign frc_den = (max_speed_reg == '0) ? CFG_W'(1) : max_speed_reg;

    always_comb
    begin
        logic [FX_W:0] mag;
        f_next = d_reg;
        for (int i = 0; i < 3; i++)
        begin
            f_next.dsgn[i] = d_reg.diff[i][FX_W];
            mag            = d_reg.diff[i][FX_W] ? -d_reg.diff[i] : d_reg.diff[i];
            f_fm_next[i]   = 64'(mag) * 64'(max_force_reg);
        end
    end

    // force dividers, an oversize quotient is flagged at entry
    logic [2:0][FRC_Q_W-1:0] frc_q;
    side_fd_t                fd_sb_reg [FRC_Q_W+1];
    side_fd_t                fd_in;

    always_comb
    begin
        fd_in = f_reg;
        for (int i = 0; i < 3; i++)
            fd_in.ovf[i] = f_fm_reg[i][62:FRC_Q_W] >= frc_den;
    end

    for (genvar i = 0; i < 3; i++) begin : g_frc
        sas_div_pipe #(
            .DEN_W (CFG_W),
            .Q_W   (FRC_Q_W)
        ) u_frc_div (
            .clk  (clk),
            .en   (en),
            .num  (f_fm_reg[i][CFG_W+FRC_Q_W-1:0]),
            .den  (frc_den),
            .quot (frc_q[i])
        );
    end

    // ---- stage O: select branch, saturate, pack
    logic                   o_vld_reg;
    logic [OUT_TDATA_W-1:0] o_data_reg, o_data_next;
    side_fd_t               fd_out;
    assign fd_out = fd_sb_reg[FRC_Q_W];

    always_comb
    begin
        logic [FX_W-1:0] f;
        o_data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (!fd_out.far)
                f = sat33(fd_out.diff[i]);
            else if (fd_out.ovf[i])
                f = fd_out.dsgn[i] ? {1'b1, {(FX_W-1){1'b0}}} : {1'b0, {(FX_W-1){1'b1}}};
            else if (!fd_out.dsgn[i])
                f = frc_q[i][FX_W-1] ? {1'b0, {(FX_W-1){1'b1}}} : frc_q[i];
            else
                f = (frc_q[i] > {1'b1, {(FX_W-1){1'b0}}})
                  ? {1'b1, {(FX_W-1){1'b0}}} : (~frc_q[i] + 1'b1);
            o_data_next[i*FX_W +: FX_W] = f;
        end
        o_data_next[3*FX_W +: CFG_W] = fd_out.reported;
    end

    // pipeline registers, all advance together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg     <= '0;
            s2_reg     <= '0;
            s2_sq_reg  <= '0;
            for (int j = 0; j <= SQRT_STEPS; j++)
            begin
                sq_sb_reg[j] <= '0;
                rad_reg[j]   <= '0;
                rem_reg[j]   <= '0;
                root_reg[j]  <= '0;
            end
            m_reg      <= '0;
            m_prod_reg <= '0;
            for (int j = 0; j <= RAMP_Q_W; j++)
                rd_sb_reg[j] <= '0;
            sp_reg       <= '0;
            sp_speed_reg <= '0;
            sp_rep_reg   <= '0;
            p_reg        <= '0;
            p_len_reg    <= '0;
            p_prod_reg   <= '0;
            for (int j = 0; j <= DES_Q_W; j++)
                dd_sb_reg[j] <= '0;
            d_reg    <= '0;
            f_reg    <= '0;
            f_fm_reg <= '0;
            for (int j = 0; j <= FRC_Q_W; j++)
                fd_sb_reg[j] <= '0;
            o_vld_reg  <= 1'b0;
            o_data_reg <= '0;
        end
        else if (en)
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s1_reg;
            s2_sq_reg <= s2_sq_next;
            sq_sb_reg[0] <= s3_next;
            for (int j = 0; j <= SQRT_STEPS; j++)
            begin
                rad_reg[j]  <= rad_next[j];
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
            end
            for (int j = 1; j <= SQRT_STEPS; j++)
                sq_sb_reg[j] <= sq_sb_reg[j-1];
            m_reg      <= m_next;
            m_prod_reg <= m_prod_next;
            rd_sb_reg[0] <= m_reg;
            for (int j = 1; j <= RAMP_Q_W; j++)
                rd_sb_reg[j] <= rd_sb_reg[j-1];
            sp_reg       <= rd_out;
            sp_speed_reg <= sp_speed_next;
            sp_rep_reg   <= sp_rep_next;
            p_reg        <= p_next;
            p_len_reg    <= sp_reg.len;
            p_prod_reg   <= p_prod_next;
            dd_sb_reg[0] <= p_reg;
            for (int j = 1; j <= DES_Q_W; j++)
                dd_sb_reg[j] <= dd_sb_reg[j-1];
            d_reg    <= d_next;
            f_reg    <= f_next;
            f_fm_reg <= f_fm_next;
            fd_sb_reg[0] <= fd_in;
            for (int j = 1; j <= FRC_Q_W; j++)
                fd_sb_reg[j] <= fd_sb_reg[j-1];
            o_vld_reg  <= fd_out.vld;
            o_data_reg <= o_data_next;
        end
    end

    // output register with skid
    logic                   out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] sk_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            out_data_reg <= '0;
            sk_vld_reg   <= 1'b0;
            sk_data_reg  <= '0;
        end
        else if (out_vld_reg && !m_tready)
        begin
            // receiver stalled: park the next result in the skid
            if (en && o_vld_reg)
            begin
                sk_vld_reg  <= 1'b1;
                sk_data_reg <= o_data_reg;
            end
        end
        else if (sk_vld_reg)
        begin
            out_vld_reg  <= 1'b1;
            out_data_reg <= sk_data_reg;
            sk_vld_reg   <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= o_vld_reg;
            out_data_reg <= o_data_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // a parked result always has a result in front of it
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sk_vld_reg |-> out_vld_reg)
        else $error("skid holds a word while the output is empty");

    // a finished result arriving at a stalled output must land in the skid
    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_tready && en && o_vld_reg) |=> sk_vld_reg)
        else $error("result dropped at a stalled output");

    // reported speed never exceeds the configured maximum
    a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3*FX_W +: CFG_W] <= max_speed_reg))
        else $error("desired speed above max speed");
`endif

endmodule
